// File: design/jse_pkg.sv
// jse_pkg: shared types, constants and helpers for the json string escaper
// depends on nothing; used by every module of the block by scoped names

package jse_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QDepth = 1 << QPtrW;
  localparam int unsigned StepW  = 3;

  localparam logic [ByteW-1:0] ChQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChU      = 8'h75;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChLowA   = 8'h61;
  localparam logic [ByteW-1:0] ChT      = 8'h74;
  localparam logic [ByteW-1:0] ChN      = 8'h6E;
  localparam logic [ByteW-1:0] ChB      = 8'h62;
  localparam logic [ByteW-1:0] ChF      = 8'h66;
  localparam logic [ByteW-1:0] ChR      = 8'h72;

  localparam logic [ByteW-1:0] MaxAscii = 8'h7F;
  localparam logic [ByteW-1:0] MaxCtrl  = 8'h1F;
  localparam logic [ByteW-1:0] CtrlTab  = 8'h09;
  localparam logic [ByteW-1:0] CtrlLf   = 8'h0A;
  localparam logic [ByteW-1:0] CtrlBs   = 8'h08;
  localparam logic [ByteW-1:0] CtrlFf   = 8'h0C;
  localparam logic [ByteW-1:0] CtrlCr   = 8'h0D;

  // how the body of one byte is written out
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,  // nothing between the quotes
    KIND_PLAIN = 2'd1,  // the character itself
    KIND_PAIR  = 2'd2,  // backslash then chr
    KIND_HEX   = 2'd3   // backslash u 0 0 and two hex digits of chr
  } kind_t;

  typedef struct packed {
    logic             has_open;
    logic             has_close;
    kind_t            kind;
    logic [ByteW-1:0] chr;
  } desc_t;

  typedef enum logic [1:0] {
    ST_HEAD  = 2'd0,
    ST_BODY  = 2'd1,
    ST_CLOSE = 2'd2
  } back_st_t;

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib);
    logic [ByteW-1:0] res;
    if (nib < 4'd10) begin
      res = ChZero + {4'd0, nib};
    end else begin
      res = ChLowA + {4'd0, nib} - 8'd10;
    end
    return res;
  endfunction

  function automatic logic [StepW-1:0] body_len(input kind_t k);
    logic [StepW-1:0] res;
    unique case (k)
      KIND_NONE:  res = 3'd0;
      KIND_PLAIN: res = 3'd1;
      KIND_PAIR:  res = 3'd2;
      KIND_HEX:   res = 3'd6;
      default:    res = 3'd0;
    endcase
    return res;
  endfunction

endpackage

// File: design/jse_front.sv
// jse_front: accepts input bytes, holds the skip_control register and
// classifies each byte into a descriptor for the queue; uses jse_pkg

module jse_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,
  input  logic                    in_tlast,
  input  logic [1:0]              in_tuser,
  input  logic                    q_full,
  output logic                    q_push,
  output jse_pkg::desc_t          q_desc
);

  logic            skip_ctrl_r;
  logic            skip_ctrl_nxt;
  jse_pkg::desc_t  desc;
  logic            emits;

  always_comb begin
    skip_ctrl_nxt = skip_ctrl_r;
    if (cfg_wr_en) begin
      skip_ctrl_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_ctrl_r <= 1'b0;
    end else begin
      skip_ctrl_r <= skip_ctrl_nxt;
    end
  end

  always_comb begin
    desc.has_open  = in_tuser[0];
    desc.has_close = in_tlast;
    desc.kind      = jse_pkg::KIND_PLAIN;
    desc.chr       = in_tdata;
    if (in_tuser[1]) begin
      // empty string: just the two quotes
      desc.has_open  = 1'b1;
      desc.has_close = 1'b1;
      desc.kind      = jse_pkg::KIND_NONE;
    end else if (in_tdata > jse_pkg::MaxAscii) begin
      desc.kind = jse_pkg::KIND_HEX;
    end else if (in_tdata == jse_pkg::ChQuote || in_tdata == jse_pkg::ChBslash) begin
      desc.kind = jse_pkg::KIND_PAIR;
    end else if (in_tdata > jse_pkg::MaxCtrl) begin
      desc.kind = jse_pkg::KIND_PLAIN;
    end else if (skip_ctrl_r) begin
      desc.kind = jse_pkg::KIND_NONE;
    end else begin
      unique case (in_tdata)
        jse_pkg::CtrlTab: begin desc.kind = jse_pkg::KIND_PAIR; desc.chr = jse_pkg::ChT; end
        jse_pkg::CtrlLf:  begin desc.kind = jse_pkg::KIND_PAIR; desc.chr = jse_pkg::ChN; end
        jse_pkg::CtrlBs:  begin desc.kind = jse_pkg::KIND_PAIR; desc.chr = jse_pkg::ChB; end
        jse_pkg::CtrlFf:  begin desc.kind = jse_pkg::KIND_PAIR; desc.chr = jse_pkg::ChF; end
        jse_pkg::CtrlCr:  begin desc.kind = jse_pkg::KIND_PAIR; desc.chr = jse_pkg::ChR; end
        default:          desc.kind = jse_pkg::KIND_HEX;
      endcase
    end
  end

  // an item with no characters at all is taken and dropped
  assign emits     = desc.has_open || desc.has_close || (desc.kind != jse_pkg::KIND_NONE);
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && emits;
  assign q_desc    = desc;

endmodule

// File: design/jse_queue.sv
// jse_queue: small descriptor queue between front and back
// uses jse_pkg for the descriptor type and depth

module jse_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jse_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output jse_pkg::desc_t head
);

  jse_pkg::desc_t                 slots_r [jse_pkg::QDepth];
  logic [jse_pkg::QPtrW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [jse_pkg::QPtrW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [jse_pkg::QPtrW:0]        count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (count_r == (jse_pkg::QPtrW+1)'(jse_pkg::QDepth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (do_push ? 1'b1 : 1'b0);
    rd_ptr_nxt = rd_ptr_r + (do_pop ? 1'b1 : 1'b0);
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// File: design/jse_back.sv
// jse_back: expands queued descriptors into json characters, one a cycle while
// the output is not stalled, into an output register; uses jse_pkg

module jse_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  jse_pkg::desc_t q_head,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic           out_tuser
);

  jse_pkg::back_st_t          st_r, st_nxt;
  logic [jse_pkg::StepW-1:0]  step_r, step_nxt;
  logic                       vld_r, vld_nxt;
  logic [7:0]                 char_r;
  logic                       last_r;
  logic                       done_r;

  logic [jse_pkg::StepW-1:0]  len;
  logic [jse_pkg::StepW-1:0]  step;
  logic                       fire;
  logic                       is_open;
  logic                       is_body;
  logic                       is_close;
  logic                       body_end;
  logic [7:0]                 cur_char;
  logic                       cur_last;

  assign len  = jse_pkg::body_len(q_head.kind);
  assign fire = !q_empty && (!vld_r || out_tready);

  // which part of the descriptor goes out this cycle
  always_comb begin
    is_open  = (st_r == jse_pkg::ST_HEAD) && q_head.has_open;
    is_body  = (st_r == jse_pkg::ST_BODY) ||
               ((st_r == jse_pkg::ST_HEAD) && !q_head.has_open && (len != '0));
    is_close = !is_open && !is_body;
    step     = (st_r == jse_pkg::ST_BODY) ? step_r : '0;
    body_end = (step == len - 1'b1);
  end

  // next state
  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    if (fire) begin
      if (cur_last) begin
        st_nxt   = jse_pkg::ST_HEAD;
        step_nxt = '0;
      end else if (is_open) begin
        st_nxt   = (len != '0) ? jse_pkg::ST_BODY : jse_pkg::ST_CLOSE;
        step_nxt = '0;
      end else if (is_body) begin
        if (body_end) begin
          st_nxt = jse_pkg::ST_CLOSE;
        end else begin
          st_nxt   = jse_pkg::ST_BODY;
          step_nxt = step + 1'b1;
        end
      end
    end
  end

  // outputs of the sequencer
  always_comb begin
    cur_char = jse_pkg::ChQuote;
    cur_last = 1'b1;
    if (is_open) begin
      cur_last = (len == '0) && !q_head.has_close;
    end else if (is_body) begin
      cur_last = body_end && !q_head.has_close;
      unique case (q_head.kind)
        jse_pkg::KIND_PLAIN: cur_char = q_head.chr;
        jse_pkg::KIND_PAIR:  cur_char = (step == '0) ? jse_pkg::ChBslash : q_head.chr;
        jse_pkg::KIND_HEX: begin
          unique case (step)
            3'd0:    cur_char = jse_pkg::ChBslash;
            3'd1:    cur_char = jse_pkg::ChU;
            3'd2:    cur_char = jse_pkg::ChZero;
            3'd3:    cur_char = jse_pkg::ChZero;
            3'd4:    cur_char = jse_pkg::hex_char(q_head.chr[7:4]);
            default: cur_char = jse_pkg::hex_char(q_head.chr[3:0]);
          endcase
        end
        default:             cur_char = jse_pkg::ChQuote;
      endcase
    end
    q_pop = fire && cur_last;
  end

  always_comb begin
    vld_nxt = vld_r;
    if (fire) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= jse_pkg::ST_HEAD;
      step_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      char_r <= cur_char;
      last_r <= cur_last;
      done_r <= is_close;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = char_r;
  assign out_tlast  = last_r;
  assign out_tuser  = done_r;

endmodule

// File: design/json_string_escaper.sv
// json_string_escaper: one input byte in, 0 to 8 json characters out.
// after its transfer, the first character of an item passes the queue write,
// then the output register.
// throughput: one character per cycle while out_tready is high; an item holds the back end
// for each character it yields (0 to 8), so plain unquoted bytes stream in at one per cycle then.
// a 4-entry descriptor queue absorbs escapes; input stalls only when it is full.
// reset (rst_n low, synchronous) clears skip_control, the queue and the output.

module json_string_escaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // skip_control
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // byte_value
  input  logic       in_tlast,      // ends_string
  input  logic [1:0] in_tuser,      // [0] starts_string, [1] empty_string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // out_char
  output logic       out_tlast,     // last_of_run
  output logic       out_tuser      // string_done
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  jse_pkg::desc_t push_desc;
  jse_pkg::desc_t head_desc;

  jse_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_desc      (push_desc)
  );

  jse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head_desc)
  );

  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (head_desc),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: tb/tb_json_string_escaper.sv
`timescale 1ns / 100ps
// tb_json_string_escaper: self-checking bench for the json string escaper
// uses jse_pkg for character constants; directed table, then random strings
// under three idle regimes, checked against an in-bench predictor

module tb_json_string_escaper;

  localparam int DirRows    = 23;
  localparam int PhaseItems = 112;
  localparam int DrainCycles = 20;
  localparam int HoldCycles = 300;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
  } json_char_t;

  // one directed row; typed rows carry the expected text literally
  typedef struct {
    logic [7:0] b;
    logic       st;
    logic       en;
    logic       em;
    logic       skip;
    bit         typed;
    string      text;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;   // skip_control
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;      // byte_value
  logic       in_tlast = 1'b0;      // ends_string
  logic [1:0] in_tuser = 2'd0;      // [0] starts_string, [1] empty_string
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;            // out_char
  logic       out_tlast;            // last_of_run
  logic       out_tuser;            // string_done

  json_char_t pending_chars[$];
  json_char_t run_q[$];
  logic       skip_model = 1'b0;
  int         errors = 0;
  int         cycles = 0;
  int         send_idle_pct = 22;
  int         recv_idle_pct = 81;
  int         hold_reqs = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  string      hex_set = "0123456789abcdef";

  dir_row_t dir_rows [DirRows] = '{
    '{8'hA5, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, "\"\""},
    '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, "\"\\u0000\""},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, "\"\\u00ff\""},
    '{8'h7F, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ""},
    '{8'h22, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, "\\\""},
    '{8'h5C, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, "\\\\"},
    '{8'h09, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ""},
    '{8'h0A, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ""},
    '{8'h08, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ""},
    '{8'h0C, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ""},
    '{8'h0D, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ""},
    '{8'h1F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ""},
    '{8'h20, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ""},
    '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ""},
    '{8'h41, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ""},
    '{8'h42, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ""},
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, "\"\""},
    '{8'h01, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, ""},
    '{8'h1F, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, "\"\""},
    '{8'h22, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, ""},
    '{8'h0A, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, ""},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ""},
    '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, "\"\""}
  };

  json_string_escaper uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void put_ch(logic [7:0] c, logic done);
    json_char_t e;
    e.ch = c;
    e.last = 1'b0;
    e.done = done;
    run_q.push_back(e);
  endfunction

  function automatic void put_u_escape(logic [7:0] b);
    put_ch(jse_pkg::ChBslash, 1'b0);
    put_ch(jse_pkg::ChU, 1'b0);
    put_ch(jse_pkg::ChZero, 1'b0);
    put_ch(jse_pkg::ChZero, 1'b0);
    put_ch(hex_set[b[7:4]], 1'b0);
    put_ch(hex_set[b[3:0]], 1'b0);
  endfunction

  // move the characters of one item onto the expected stream, marking its final one
  function automatic void commit_run();
    if (run_q.size() != 0) run_q[run_q.size()-1].last = 1'b1;
    foreach (run_q[i]) pending_chars.push_back(run_q[i]);
    run_q.delete();
  endfunction

  function automatic void escape_byte(logic [7:0] b, logic st, logic en, logic em);
    run_q.delete();
    if (em) begin
      put_ch(jse_pkg::ChQuote, 1'b0);
      put_ch(jse_pkg::ChQuote, 1'b1);
    end else begin
      if (st) put_ch(jse_pkg::ChQuote, 1'b0);
      if (b > jse_pkg::MaxAscii) begin
        put_u_escape(b);
      end else if (b == jse_pkg::ChQuote || b == jse_pkg::ChBslash) begin
        put_ch(jse_pkg::ChBslash, 1'b0);
        put_ch(b, 1'b0);
      end else if (b > jse_pkg::MaxCtrl) begin
        put_ch(b, 1'b0);
      end else if (!skip_model) begin
        case (b)
          jse_pkg::CtrlTab: begin
            put_ch(jse_pkg::ChBslash, 1'b0);
            put_ch(jse_pkg::ChT, 1'b0);
          end
          jse_pkg::CtrlLf: begin
            put_ch(jse_pkg::ChBslash, 1'b0);
            put_ch(jse_pkg::ChN, 1'b0);
          end
          jse_pkg::CtrlBs: begin
            put_ch(jse_pkg::ChBslash, 1'b0);
            put_ch(jse_pkg::ChB, 1'b0);
          end
          jse_pkg::CtrlFf: begin
            put_ch(jse_pkg::ChBslash, 1'b0);
            put_ch(jse_pkg::ChF, 1'b0);
          end
          jse_pkg::CtrlCr: begin
            put_ch(jse_pkg::ChBslash, 1'b0);
            put_ch(jse_pkg::ChR, 1'b0);
          end
          default: put_u_escape(b);
        endcase
      end
      if (en) put_ch(jse_pkg::ChQuote, 1'b1);
    end
    commit_run();
  endfunction

  // typed rows: the closing quote, when present, is always the final character
  function automatic void expect_text(string t, logic closes);
    run_q.delete();
    for (int i = 0; i < t.len(); i++) begin
      put_ch(t[i], closes && (i == t.len() - 1));
    end
    commit_run();
  endfunction

  function automatic void note_error(string what, json_char_t want);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] %s: want ch=%h last=%b done=%b, got ch=%h last=%b done=%b",
               $realtime, what, want.ch, want.last, want.done,
               out_tdata, out_tlast, out_tuser);
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(9))
      0, 1, 2, 3: b = 8'($urandom_range(8'h7E, 8'h20));
      4: b = 8'($urandom_range(jse_pkg::MaxCtrl));
      5: b = 8'($urandom_range(8'hFF, 8'h80));
      6: b = $urandom_range(1) ? jse_pkg::ChQuote : jse_pkg::ChBslash;
      7: begin
        case ($urandom_range(5))
          0: b = jse_pkg::CtrlTab;
          1: b = jse_pkg::CtrlLf;
          2: b = jse_pkg::CtrlBs;
          3: b = jse_pkg::CtrlFf;
          4: b = jse_pkg::CtrlCr;
          default: b = jse_pkg::MaxAscii;
        endcase
      end
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // call at a rising edge; returns at the edge where the transfer happened
  task automatic send_byte(logic [7:0] b, logic st, logic en, logic em,
                           bit typed, string text);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= en;
    in_tuser  <= {em, st};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (typed) expect_text(text, en || em);
    else escape_byte(b, st, en, em);
  endtask

  // register writes only once the block has drained
  task automatic write_skip(logic v);
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    skip_model = v;
  endtask

  // mostly well-formed strings with random content, some loose bytes as noise
  task automatic send_strings(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(6);
        if (len == 0) begin
          send_byte(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1, 0, "");
          sent++;
        end else begin
          for (int k = 0; k < len; k++) begin
            send_byte(pick_byte(), k == 0, k == len - 1, 1'b0, 0, "");
            sent++;
          end
        end
      end else begin
        send_byte(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(3) == 0), 0, "");
        sent++;
      end
    end
  endtask

  // result side: check each transfer, then drive ready for the next edge
  always @(posedge clk) begin
    json_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        want = '0;
        note_error("unexpected character", want);
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== want.ch || out_tlast !== want.last || out_tuser !== want.done)
          note_error("character mismatch", want);
      end
    end
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb_json_string_escaper NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_skip(1'b0);

    for (int r = 0; r < DirRows; r++) begin
      if (dir_rows[r].skip != skip_model) write_skip(dir_rows[r].skip);
      send_byte(dir_rows[r].b, dir_rows[r].st, dir_rows[r].en, dir_rows[r].em,
                dir_rows[r].typed, dir_rows[r].text);
    end

    write_skip(1'b0);
    send_strings(PhaseItems);

    write_skip(1'b1);
    send_idle_pct = 81;
    recv_idle_pct = 22;
    send_strings(PhaseItems);

    write_skip(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long receiver stall while the sender keeps pushing
    hold_reqs++;
    send_strings(PhaseItems);

    write_skip(1'b1);
    send_strings(PhaseItems);

    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("tb_json_string_escaper OK");
    end else begin
      $display("tb_json_string_escaper NOT OK");
    end
    $finish;
  end

endmodule
